// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of the handle allocator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GHA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gha_pkg.sv -----
// Shared types, constants and command/status codes of the handle allocator.
// No dependencies.
package gha_pkg;

    // Field widths of the command and result transfers.
    localparam int CMD_W = 2;
    localparam int STAT_W = 2;
    localparam int ID_W = 10;
    localparam int GEN_W = 32;

    // Default configuration of the slot table.
    localparam int SLOTS_DEF = 1024;
    localparam int GEN_BITS_DEF = 32;

    // The alive bitmap is scanned one word per cycle.
    localparam int WB = 32;
    localparam int BW = $clog2(WB);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INSPECT = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
    localparam logic [STAT_W-1:0] STAT_LOCKED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_FREE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_STALE = 2'd3;

    // One command transfer.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ID_W-1:0]  range_low;
        logic [ID_W-1:0]  range_high;
        logic [ID_W-1:0]  handle_id;
        logic [GEN_W-1:0] handle_generation;
    } t_gha_req;

    // One result transfer.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   slot_id;
        logic [GEN_W-1:0]  generation;
        logic              alive;
        logic [ID_W-1:0]   highest_slot_used;
    } t_gha_rsp;

    // Outcome of searching one bitmap word for a free slot.
    typedef struct packed {
        logic          found;
        logic [BW-1:0] bit_idx;
    } t_gha_hit;

endpackage

// ----- hdl/gha_free_search.sv -----
// Free-slot search over one word of the alive bitmap: masks the range ends and
// returns the lowest clear bit. Depends on gha_pkg.
module gha_free_search
    import gha_pkg::*;
(
    input  logic [WB-1:0] i_word,
    input  logic          i_first,
    input  logic          i_last,
    input  logic [BW-1:0] i_lo_bit,
    input  logic [BW-1:0] i_hi_bit,
    output t_gha_hit      o_hit
);

    localparam logic [BW-1:0] TOP_BIT = BW'(WB - 1);

    logic [WB-1:0] lo_mask;
    logic [WB-1:0] hi_mask;
    logic [WB-1:0] free_bits;

    // Only the first and last words of the range are trimmed.
    assign lo_mask = i_first ? ({WB{1'b1}} << i_lo_bit) : {WB{1'b1}};
    assign hi_mask = i_last ? ({WB{1'b1}} >> (TOP_BIT - i_hi_bit)) : {WB{1'b1}};
    assign free_bits = ~i_word & lo_mask & hi_mask;

    // Lowest set bit wins.
    always_comb begin
        o_hit.found = |free_bits;
        o_hit.bit_idx = '0;
        for (int b = WB - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                o_hit.bit_idx = BW'(b);
            end
        end
    end

endmodule

// ----- hdl/generational_handle_allocator_unit.sv -----
// Top level of the generational handle allocator: sequencer, slot memories and
// the lock register. Depends on gha_pkg and gha_free_search.
//
//  Channel   Signals                                Transfer when
//  --------  -------------------------------------  -----------------------------
//  command   i_start, o_busy, i_req                 i_start high and o_busy low
//  result    o_rsp_valid, o_rsp                     o_rsp_valid high (one cycle)
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data   i_cfg_valid and o_cfg_ready
//
// Allocate stays busy while it scans the words of the range up to the first free slot, one
// word of 32 slots per cycle through the shared search unit, then in S_ALLOC if one is found.
// Release and inspect stay busy in S_EVAL. A locked or empty-range allocate, or a release or
// inspect with an out-of-range handle, is answered without going busy. For a busy command the
// result strobe shows in the first cycle with busy low. After reset a clearing pass over every
// slot presets the memories with busy high. The receiver cannot stall.
module generational_handle_allocator_unit
    import gha_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int GEN_BITS = GEN_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_busy,
    input  t_gha_req i_req,
    output logic     o_rsp_valid,
    output t_gha_rsp o_rsp,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  logic     i_cfg_data
);

    localparam int SW = $clog2(SLOTS);
    localparam int NWORDS = (SLOTS + WB - 1) / WB;
    localparam int WAW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int CW = ((SW > ID_W) ? SW : ID_W) + 1;
    localparam int GCW = (GEN_BITS > GEN_W) ? GEN_BITS : GEN_W;
    localparam logic [CW-1:0] LAST_SLOT = CW'(SLOTS - 1);
    localparam logic [SW-1:0] LAST_CLR = SW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_ALLOC,
        S_EVAL
    } t_state;

    t_state        r_state, n_state;
    logic [SW-1:0] r_clr, n_clr;
    logic          r_locked;
    t_gha_req      r_req, n_req;
    logic [WAW-1:0] r_word, n_word;
    logic [WAW-1:0] r_lo_word, n_lo_word;
    logic [WAW-1:0] r_hi_word, n_hi_word;
    logic [BW-1:0] r_lo_bit, n_lo_bit;
    logic [BW-1:0] r_hi_bit, n_hi_bit;
    logic [SW-1:0] r_slot, n_slot;
    logic [WB-1:0] r_aword, n_aword;
    logic [SW-1:0] r_high, n_high;
    t_gha_rsp      r_rsp, n_rsp;
    logic          r_rsp_valid, n_rsp_valid;

    // Slot memories with registered read data.
    logic [GEN_BITS-1:0] r_gen_mem [SLOTS];
    logic [WB-1:0]       r_alive_mem [NWORDS];
    logic [GEN_BITS-1:0] r_gen_q;
    logic [WB-1:0]       r_alive_q;

    logic                gen_we;
    logic [SW-1:0]       gen_waddr;
    logic [GEN_BITS-1:0] gen_wdata;
    logic [SW-1:0]       gen_raddr;
    logic                alive_we;
    logic [WAW-1:0]      alive_waddr;
    logic [WB-1:0]       alive_wdata;
    logic [WAW-1:0]      alive_raddr;

    logic [CW-1:0]       req_lo;
    logic [CW-1:0]       req_hi_raw;
    logic [CW-1:0]       req_hi;
    logic [CW-1:0]       req_id;
    logic                req_empty;
    logic                req_id_ok;
    logic [CW-1:0]       hit_slot;
    logic [GEN_BITS-1:0] gen_next;
    logic                id_alive;
    logic                gen_match;
    t_gha_hit            hit;

    function automatic t_gha_rsp make_rsp(
        input logic [STAT_W-1:0] status,
        input logic [ID_W-1:0]   slot_id,
        input logic [GEN_W-1:0]  generation,
        input logic              alive,
        input logic [ID_W-1:0]   highest
    );
        t_gha_rsp rsp;
        rsp.status = status;
        rsp.slot_id = slot_id;
        rsp.generation = generation;
        rsp.alive = alive;
        rsp.highest_slot_used = highest;
        return rsp;
    endfunction

    // Command decode: clamp the range and check the handle index.
    assign req_lo = CW'(i_req.range_low);
    assign req_hi_raw = CW'(i_req.range_high);
    assign req_hi = (req_hi_raw > LAST_SLOT) ? LAST_SLOT : req_hi_raw;
    assign req_empty = req_lo > req_hi;
    assign req_id = CW'(i_req.handle_id);
    assign req_id_ok = req_id <= LAST_SLOT;

    // Shared search unit over the current bitmap word.
    gha_free_search u_search (
        .i_word   (r_alive_q),
        .i_first  (r_word == r_lo_word),
        .i_last   (r_word == r_hi_word),
        .i_lo_bit (r_lo_bit),
        .i_hi_bit (r_hi_bit),
        .o_hit    (hit)
    );

    assign hit_slot = (CW'(r_word) << BW) | CW'(hit.bit_idx);
    assign gen_next = r_gen_q + GEN_BITS'(1);
    assign id_alive = r_alive_q[r_lo_bit];
    assign gen_match = GCW'(r_gen_q) == GCW'(r_req.handle_generation);

    // Sequencer next-state and memory control.
    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_req = r_req;
        n_word = r_word;
        n_lo_word = r_lo_word;
        n_hi_word = r_hi_word;
        n_lo_bit = r_lo_bit;
        n_hi_bit = r_hi_bit;
        n_slot = r_slot;
        n_aword = r_aword;
        n_high = r_high;
        n_rsp = r_rsp;
        n_rsp_valid = 1'b0;
        gen_we = 1'b0;
        gen_waddr = r_slot;
        gen_wdata = gen_next;
        gen_raddr = r_slot;
        alive_we = 1'b0;
        alive_waddr = r_word;
        alive_wdata = r_aword;
        alive_raddr = r_word;

        unique case (r_state)
            S_CLEAR: begin
                gen_we = 1'b1;
                gen_waddr = r_clr;
                gen_wdata = '1;
                alive_we = 1'b1;
                alive_waddr = WAW'(r_clr >> BW);
                alive_wdata = '0;
                n_clr = r_clr + SW'(1);
                if (r_clr == LAST_CLR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    if (i_req.command == CMD_ALLOC) begin
                        if (r_locked) begin
                            n_rsp_valid = 1'b1;
                            n_rsp = make_rsp(STAT_LOCKED, '0, '0, 1'b0, ID_W'(r_high));
                        end else if (req_empty) begin
                            n_rsp_valid = 1'b1;
                            n_rsp = make_rsp(STAT_NO_FREE, '0, '0, 1'b0, ID_W'(r_high));
                        end else begin
                            n_word = WAW'(req_lo >> BW);
                            alive_raddr = WAW'(req_lo >> BW);
                            n_lo_word = WAW'(req_lo >> BW);
                            n_hi_word = WAW'(req_hi >> BW);
                            n_lo_bit = req_lo[BW-1:0];
                            n_hi_bit = req_hi[BW-1:0];
                            n_state = S_SCAN;
                        end
                    end else if (!req_id_ok) begin
                        n_rsp_valid = 1'b1;
                        n_rsp = make_rsp(
                            (i_req.command == CMD_RELEASE && r_locked) ? STAT_LOCKED
                                                                        : STAT_STALE,
                            i_req.handle_id, '0, 1'b0, ID_W'(r_high));
                    end else begin
                        n_slot = SW'(req_id);
                        gen_raddr = SW'(req_id);
                        n_word = WAW'(req_id >> BW);
                        alive_raddr = WAW'(req_id >> BW);
                        n_lo_bit = req_id[BW-1:0];
                        n_state = S_EVAL;
                    end
                end
            end
            S_SCAN: begin
                if (hit.found) begin
                    n_slot = SW'(hit_slot);
                    gen_raddr = SW'(hit_slot);
                    n_aword = r_alive_q | (WB'(1) << hit.bit_idx);
                    n_state = S_ALLOC;
                end else if (r_word == r_hi_word) begin
                    n_rsp_valid = 1'b1;
                    n_rsp = make_rsp(STAT_NO_FREE, '0, '0, 1'b0, ID_W'(r_high));
                    n_state = S_IDLE;
                end else begin
                    n_word = r_word + WAW'(1);
                    alive_raddr = r_word + WAW'(1);
                end
            end
            S_ALLOC: begin
                gen_we = 1'b1;
                alive_we = 1'b1;
                n_high = (r_slot > r_high) ? r_slot : r_high;
                n_rsp_valid = 1'b1;
                n_rsp = make_rsp(STAT_OK, ID_W'(r_slot), GEN_W'(gen_next), 1'b1,
                                 ID_W'(n_high));
                n_state = S_IDLE;
            end
            S_EVAL: begin
                n_rsp_valid = 1'b1;
                n_state = S_IDLE;
                if (r_req.command == CMD_RELEASE) begin
                    if (r_locked) begin
                        n_rsp = make_rsp(STAT_LOCKED, r_req.handle_id, GEN_W'(r_gen_q),
                                         id_alive, ID_W'(r_high));
                    end else if (!id_alive || !gen_match) begin
                        n_rsp = make_rsp(STAT_STALE, r_req.handle_id, GEN_W'(r_gen_q),
                                         id_alive, ID_W'(r_high));
                    end else begin
                        alive_we = 1'b1;
                        alive_wdata = r_alive_q & ~(WB'(1) << r_lo_bit);
                        n_rsp = make_rsp(STAT_OK, r_req.handle_id, GEN_W'(r_gen_q),
                                         1'b0, ID_W'(r_high));
                    end
                end else begin
                    n_rsp = make_rsp(STAT_OK, r_req.handle_id, GEN_W'(r_gen_q),
                                     id_alive, ID_W'(r_high));
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, lock register and registered outputs.
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_word <= n_word;
        r_lo_word <= n_lo_word;
        r_hi_word <= n_hi_word;
        r_lo_bit <= n_lo_bit;
        r_hi_bit <= n_hi_bit;
        r_slot <= n_slot;
        r_aword <= n_aword;
        r_rsp <= n_rsp;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_locked <= 1'b0;
            r_high <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_high <= n_high;
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg_valid) begin
                r_locked <= i_cfg_data;
            end
        end
    end

    // Generation and alive memories.
    always_ff @(posedge i_clk) begin
        if (gen_we) begin
            r_gen_mem[gen_waddr] <= gen_wdata;
        end
        r_gen_q <= r_gen_mem[gen_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (alive_we) begin
            r_alive_mem[alive_waddr] <= alive_wdata;
        end
        r_alive_q <= r_alive_mem[alive_raddr];
    end

    assign o_busy = r_state != S_IDLE;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp = r_rsp;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- hdl/gha_checker.sv -----
// Port-level checker of the handle allocator and its bind to the top level.
// Depends on gha_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gha_checker
    import gha_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_start,
    input logic     o_busy,
    input t_gha_req i_req,
    input logic     o_rsp_valid,
    input t_gha_rsp o_rsp,
    input logic     i_cfg_valid,
    input logic     o_cfg_ready,
    input logic     i_cfg_data
);

    // An accepted command either goes busy or answers in the next cycle.
    `GHA_ASSERT_NEXT(a_start_progress, i_start && !o_busy, o_busy || o_rsp_valid, "command lost")

    // A result is only shown while the block is idle.
    `GHA_ASSERT_NOW(a_rsp_idle, o_rsp_valid, !o_busy, "result while busy")

    // Without a new command transfer the strobe lasts one cycle.
    `GHA_ASSERT_NEXT(a_rsp_once, o_rsp_valid && !(i_start && !o_busy), !o_rsp_valid, "repeated result")

    // A failed allocation reports an empty slot.
    `GHA_ASSERT_NOW(a_nofree_zero, o_rsp_valid && o_rsp.status == STAT_NO_FREE, o_rsp.slot_id == '0 && o_rsp.generation == '0 && !o_rsp.alive, "bad no-free result")

endmodule

bind generational_handle_allocator_unit gha_checker u_gha_checker (.*);

// ----- tb/generational_handle_allocator_unit_tb.sv -----
// Self-checking testbench of the generational handle allocator: a table model
// predicts every result, and plain tasks drive the command and config channels.
// Depends on gha_pkg and the generational_handle_allocator_unit RTL.
import gha_pkg::*;

// Predicts results from its own copy of the slot table and holds them until checked.
class handle_table_model;
    bit               slot_alive[SLOTS_DEF];
    logic [GEN_W-1:0] slot_gen[SLOTS_DEF];
    logic [ID_W-1:0]  high_water;
    bit               locked;
    t_gha_rsp         pending_rsps[$];
    int               errors;
    int               checked;
    int               status_seen[4];
    int               cmd_seen[4];

    function new();
        foreach (slot_alive[i]) begin
            slot_alive[i] = 1'b0;
            slot_gen[i] = '1;
        end
        high_water = '0;
        locked = 1'b0;
        errors = 0;
        checked = 0;
    endfunction

    // Fill in the slot fields of a release or inspect result.
    function t_gha_rsp slot_report(logic [STAT_W-1:0] st, logic [ID_W-1:0] id);
        t_gha_rsp e;
        e = '0;
        e.status = st;
        e.slot_id = id;
        if (int'(id) < SLOTS_DEF) begin
            e.generation = slot_gen[id];
            e.alive = slot_alive[id];
        end
        return e;
    endfunction

    // Apply one accepted command to the table and queue the result it causes.
    function void predict_command(t_gha_req r);
        t_gha_rsp e;
        int       top;
        int       s;
        bit       found;
        e = '0;
        found = 1'b0;
        cmd_seen[r.command]++;
        if (r.command == CMD_ALLOC) begin
            if (locked) begin
                e.status = STAT_LOCKED;
            end else begin
                // The upper end of the range is clamped to the table size.
                top = (int'(r.range_high) > SLOTS_DEF - 1) ? SLOTS_DEF - 1
                                                          : int'(r.range_high);
                e.status = STAT_NO_FREE;
                for (s = int'(r.range_low); s <= top && !found; s++) begin
                    if (!slot_alive[s]) begin
                        found = 1'b1;
                        slot_gen[s] = slot_gen[s] + 1'b1;
                        slot_alive[s] = 1'b1;
                        if (s > int'(high_water))
                            high_water = s[ID_W-1:0];
                        e.status = STAT_OK;
                        e.slot_id = s[ID_W-1:0];
                        e.generation = slot_gen[s];
                        e.alive = 1'b1;
                    end
                end
            end
        end else if (r.command == CMD_RELEASE) begin
            if (locked) begin
                e = slot_report(STAT_LOCKED, r.handle_id);
            end else if (int'(r.handle_id) >= SLOTS_DEF || !slot_alive[r.handle_id]
                         || slot_gen[r.handle_id] != r.handle_generation) begin
                e = slot_report(STAT_STALE, r.handle_id);
            end else begin
                slot_alive[r.handle_id] = 1'b0;
                e = slot_report(STAT_OK, r.handle_id);
            end
        end else begin
            // Inspect; the unused fourth code behaves the same way.
            e = slot_report(int'(r.handle_id) >= SLOTS_DEF ? STAT_STALE : STAT_OK,
                            r.handle_id);
        end
        e.highest_slot_used = high_water;
        pending_rsps = {pending_rsps, e};
    endfunction

    function void report_error(string what, t_gha_rsp want, t_gha_rsp got);
        errors++;
        if (errors <= 10) begin
            $display("ERROR %s: want st=%0d id=%0d gen=%h alive=%0d hi=%0d",
                     what, want.status, want.slot_id, want.generation, want.alive,
                     want.highest_slot_used);
            $display("      got  st=%0d id=%0d gen=%h alive=%0d hi=%0d",
                     got.status, got.slot_id, got.generation, got.alive,
                     got.highest_slot_used);
        end
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_rsp(t_gha_rsp got);
        t_gha_rsp want;
        if (pending_rsps.size() == 0) begin
            report_error("result with nothing outstanding", '0, got);
            return;
        end
        want = pending_rsps.pop_front();
        checked++;
        status_seen[want.status]++;
        if (got.status !== want.status || got.slot_id !== want.slot_id
            || got.generation !== want.generation || got.alive !== want.alive
            || got.highest_slot_used !== want.highest_slot_used)
            report_error("result mismatch", want, got);
    endfunction

    // Every prediction still waiting at the end is a failure.
    function void flush_leftovers();
        while (pending_rsps.size() != 0)
            report_error("result never arrived", pending_rsps.pop_front(), '0);
    endfunction
endclass

module generational_handle_allocator_unit_tb;

    localparam logic [CMD_W-1:0] CMD_INSPECT_ALT = 2'd3;
    localparam int WINDOW_TOP = 52;
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 2000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_start = 1'b0;
    logic     o_busy;
    t_gha_req i_req = '0;
    logic     o_rsp_valid;
    t_gha_rsp o_rsp;
    logic     i_cfg_valid = 1'b0;
    logic     o_cfg_ready;
    logic     i_cfg_data = 1'b0;

    handle_table_model table_model = new();
    int burst_left = 1;
    int lock_writes = 0;
    int idle_cycles = 0;

    generational_handle_allocator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Every result strobe is one transfer; check it against the table model.
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid)
            table_model.check_rsp(o_rsp);
    end

    // Stop the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_rsp_valid
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d cycles without a transfer", IDLE_LIMIT);
            $display("generational_handle_allocator_unit_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one command and hold it until the block takes it, then pause per burst.
    task automatic issue(input t_gha_req r);
        int gap;
        i_start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_busy);
        table_model.predict_command(r);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
        end
    endtask

    // Hold off commands until every predicted result has come back.
    task automatic wait_drained();
        int spin;
        spin = 0;
        i_start <= 1'b0;
        while (table_model.pending_rsps.size() != 0 && spin < 2000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Write the lock register while the block is idle.
    task automatic write_lock(input logic value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        table_model.locked = value;
        lock_writes++;
    endtask

    function automatic t_gha_req make_cmd(logic [CMD_W-1:0] c, int lo, int hi, int id,
                                          logic [GEN_W-1:0] g);
        t_gha_req r;
        r.command = c;
        r.range_low = lo[ID_W-1:0];
        r.range_high = hi[ID_W-1:0];
        r.handle_id = id[ID_W-1:0];
        r.handle_generation = g;
        return r;
    endfunction

    // Mostly the busy low window, some near the top, some anywhere.
    function automatic int pick_slot();
        int v;
        v = $urandom_range(0, 19);
        if (v < 15)
            return $urandom_range(0, WINDOW_TOP);
        else if (v < 17)
            return $urandom_range(1000, 1023);
        return $urandom_range(0, 1023);
    endfunction

    // Random command biased toward live handles so that releases mostly succeed.
    function automatic t_gha_req random_command();
        t_gha_req r;
        int       pick;
        int       v;
        int       lo;
        int       id;
        int       tries;
        r = {$urandom(), $urandom()};
        pick = $urandom_range(0, 99);
        v = $urandom_range(0, 9);
        if (pick < 38) begin
            r.command = CMD_ALLOC;
            if (v < 7) begin
                lo = $urandom_range(0, WINDOW_TOP - 12);
                r.range_low = lo[ID_W-1:0];
                r.range_high = 10'(lo + $urandom_range(0, 12));
            end else if (v == 7) begin
                lo = $urandom_range(1, 1023);
                r.range_low = lo[ID_W-1:0];
                r.range_high = 10'($urandom_range(0, lo - 1));
            end else if (v == 9) begin
                r.range_low = 10'($urandom_range(1000, 1023));
                r.range_high = '1;
            end
        end else if (pick < 73) begin
            r.command = CMD_RELEASE;
            id = pick_slot();
            for (tries = 0; tries < 8 && !table_model.slot_alive[id]; tries++)
                id = pick_slot();
            r.handle_id = id[ID_W-1:0];
            if (v < 7)
                r.handle_generation = table_model.slot_gen[id];
            else if (v < 9)
                r.handle_generation = table_model.slot_gen[id]
                                      ^ (32'd1 << $urandom_range(0, 31));
        end else begin
            r.command = (pick < 95) ? CMD_INSPECT : CMD_INSPECT_ALT;
            r.handle_id = 10'(pick_slot());
        end
        return r;
    endfunction

    initial begin
        int done;
        int seg;
        int seg_len;
        int k;
        int spin;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset contents, first use, full and empty ranges, stale handles, the lock.
        issue(make_cmd(CMD_INSPECT, 0, 0, 0, 0));
        issue(make_cmd(CMD_INSPECT, 0, 0, 1023, '1));
        issue(make_cmd(CMD_ALLOC, 0, 0, 0, 0));
        issue(make_cmd(CMD_ALLOC, 0, 0, 0, 0));
        issue(make_cmd(CMD_ALLOC, 5, 3, 0, 0));
        issue(make_cmd(CMD_ALLOC, 1023, 1023, 1023, '1));
        issue(make_cmd(CMD_ALLOC, 0, 1023, 0, 0));
        issue(make_cmd(CMD_RELEASE, 0, 0, 0, 0));
        issue(make_cmd(CMD_RELEASE, 0, 0, 0, 0));
        issue(make_cmd(CMD_RELEASE, 1023, 1023, 1, '1));
        issue(make_cmd(CMD_RELEASE, 0, 0, 1, 0));
        issue(make_cmd(CMD_INSPECT_ALT, 0, 0, 1023, 0));
        issue(make_cmd(CMD_ALLOC, 0, 1023, 0, 0));
        issue(make_cmd(CMD_RELEASE, 0, 0, 1023, 0));
        write_lock(1'b1);
        issue(make_cmd(CMD_ALLOC, 0, 1023, 0, 0));
        issue(make_cmd(CMD_RELEASE, 0, 0, 0, 32'd1));
        issue(make_cmd(CMD_INSPECT, 0, 0, 0, 0));
        issue(make_cmd(CMD_INSPECT_ALT, 0, 0, 1023, 0));
        write_lock(1'b0);
        issue(make_cmd(CMD_RELEASE, 0, 0, 0, 32'd1));
        issue(make_cmd(CMD_INSPECT, 0, 0, 0, 0));

        // Random segments; every fourth one runs with the table locked.
        done = 0;
        seg = 0;
        while (done < RANDOM_ITEMS) begin
            write_lock(seg % 4 == 3);
            seg_len = (seg % 4 == 3) ? 40 : 200;
            for (k = 0; k < seg_len; k++) begin
                issue(random_command());
                // Once per segment let everything drain before going on.
                if (k == seg_len / 2)
                    wait_drained();
            end
            done += seg_len;
            seg++;
        end

        // Drain the last results, then wait for any stray results.
        i_start <= 1'b0;
        spin = 0;
        while (table_model.pending_rsps.size() != 0 && spin < 2000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (8) @(posedge i_clk);
        table_model.flush_leftovers();

        $display("Ran %0d allocates, %0d releases, %0d inspects (%0d via the spare code)",
                 table_model.cmd_seen[CMD_ALLOC], table_model.cmd_seen[CMD_RELEASE],
                 table_model.cmd_seen[CMD_INSPECT] + table_model.cmd_seen[CMD_INSPECT_ALT],
                 table_model.cmd_seen[CMD_INSPECT_ALT]);
        $display("%0d lock writes; checked %0d results: %0d ok, %0d locked, %0d no free, %0d stale",
                 lock_writes, table_model.checked, table_model.status_seen[STAT_OK],
                 table_model.status_seen[STAT_LOCKED], table_model.status_seen[STAT_NO_FREE],
                 table_model.status_seen[STAT_STALE]);
        if (table_model.errors == 0) begin
            $display("generational_handle_allocator_unit_tb OK");
        end else begin
            $display("generational_handle_allocator_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
